// ===== hdl/ccal_pkg.sv =====
// ----------------------------------------------------------------------------
// ccal_pkg
// Shared types, constants and calendar helper functions for the clock and
// calendar block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccal_pkg;

  // Operation codes carried on the input side.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_TIME  = 2'd1,
    OP_SET_DATE  = 2'd2,
    OP_SET_ALARM = 2'd3
  } op_e;

  localparam logic [5:0]  SecMax     = 6'd59;
  localparam logic [5:0]  MinMax     = 6'd59;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [13:0] YearLast   = 14'd9999;
  localparam logic [13:0] YearLimit  = 14'd10000;
  localparam logic [13:0] YearWrapTo = 14'd1971;

  // Multiplicative inverse of 25 modulo 2**14, and the largest product that
  // a multiple of 25 can give.
  localparam logic [13:0] Inv25      = 14'd7209;
  localparam logic [13:0] Div25Bound = 14'd655;

  typedef struct packed {
    op_e         op;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
  } item_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        fired;
    logic        reject;
  } res_t;

  // Gregorian leap year. A multiple of 100 is a multiple of 4 and of 25, a
  // multiple of 400 is a multiple of 16 and of 25.
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = 14'(y * Inv25);
    div25 = (prod <= Div25Bound);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // Days in a month; zero for a month number outside 1 to 12.
  function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                   len = 5'd30;
      7'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic time_valid(input logic [6:0] h, input logic [6:0] m,
                                      input logic [6:0] s);
    return (s <= {1'b0, SecMax}) && (m <= {1'b0, MinMax}) && (h <= {2'b0, HourMax});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ccal_core.sv =====
// ----------------------------------------------------------------------------
// ccal_core
// Time, date and alarm state with the combinational update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module ccal_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire ccal_pkg::item_t item_i,
  output ccal_pkg::res_t      res_o
);

  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [5:0]  al_sec_q, al_sec_d;
  logic [5:0]  al_min_q, al_min_d;
  logic [4:0]  al_hour_q, al_hour_d;
  logic        armed_q, armed_d;

  logic        fired;
  logic        reject;
  logic [4:0]  mlen_cur;
  logic [4:0]  mlen_set;
  logic        set_time_ok;

  assign mlen_cur    = ccal_pkg::month_len({3'b0, month_q}, ccal_pkg::is_leap(year_q));
  assign mlen_set    = ccal_pkg::month_len(item_i.month, ccal_pkg::is_leap(item_i.year));
  assign set_time_ok = ccal_pkg::time_valid(item_i.hour, item_i.minute, item_i.second);

  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    al_sec_d  = al_sec_q;
    al_min_d  = al_min_q;
    al_hour_d = al_hour_q;
    armed_d   = armed_q;
    fired     = 1'b0;
    reject    = 1'b0;

    case (item_i.op)
      ccal_pkg::OP_TICK: begin
        // Ripple the carry from seconds up through the year.
        if (sec_q >= ccal_pkg::SecMax) begin
          sec_d = '0;
          if (min_q >= ccal_pkg::MinMax) begin
            min_d = '0;
            if (hour_q >= ccal_pkg::HourMax) begin
              hour_d = '0;
              if (day_q < mlen_cur) begin
                day_d = day_q + 5'd1;
              end else begin
                day_d = 5'd1;
                if (month_q >= 4'd12) begin
                  month_d = 4'd1;
                  year_d  = (year_q >= ccal_pkg::YearLast) ? ccal_pkg::YearWrapTo
                                                           : year_q + 14'd1;
                end else begin
                  month_d = month_q + 4'd1;
                end
              end
            end else begin
              hour_d = hour_q + 5'd1;
            end
          end else begin
            min_d = min_q + 6'd1;
          end
        end else begin
          sec_d = sec_q + 6'd1;
        end
        if (armed_q && (sec_d == al_sec_q) && (min_d == al_min_q) &&
            (hour_d == al_hour_q)) begin
          fired   = 1'b1;
          armed_d = 1'b0;
        end
      end
      ccal_pkg::OP_SET_TIME: begin
        if (set_time_ok) begin
          hour_d = item_i.hour[4:0];
          min_d  = item_i.minute[5:0];
          sec_d  = item_i.second[5:0];
        end else begin
          reject = 1'b1;
        end
      end
      ccal_pkg::OP_SET_DATE: begin
        if ((item_i.year < ccal_pkg::YearLimit) && (item_i.day != 7'd0) &&
            (item_i.day <= {2'b0, mlen_set})) begin
          day_d   = item_i.day[4:0];
          month_d = item_i.month[3:0];
          year_d  = item_i.year;
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
        // Set alarm.
        if (set_time_ok) begin
          al_hour_d = item_i.hour[4:0];
          al_min_d  = item_i.minute[5:0];
          al_sec_d  = item_i.second[5:0];
          armed_d   = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      day_q     <= 5'd1;
      month_q   <= 4'd1;
      year_q    <= ccal_pkg::YearWrapTo;
      al_sec_q  <= '0;
      al_min_q  <= '0;
      al_hour_q <= '0;
      armed_q   <= 1'b0;
    end else if (step_i) begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      day_q     <= day_d;
      month_q   <= month_d;
      year_q    <= year_d;
      al_sec_q  <= al_sec_d;
      al_min_q  <= al_min_d;
      al_hour_q <= al_hour_d;
      armed_q   <= armed_d;
    end
  end

  always_comb begin
    res_o.second = sec_d;
    res_o.minute = min_d;
    res_o.hour   = hour_d;
    res_o.day    = day_d;
    res_o.month  = month_d;
    res_o.year   = year_d;
    res_o.fired  = fired;
    res_o.reject = reject;
  end

endmodule

`default_nettype wire

// ===== hdl/clock_calendar_with_alarm.sv =====
// ----------------------------------------------------------------------------
// clock_calendar_with_alarm
// Time-of-day and Gregorian calendar counter with a one-shot alarm.
// ----------------------------------------------------------------------------
`default_nettype none

// Every input transaction produces exactly one output transaction. A tick
// advances the clock by one second, carrying into minutes, hours, days,
// months and years (leap years follow the Gregorian rule, and the year wraps
// from 9999 to 1971). Set-time, set-date and set-alarm transactions are
// checked and applied only when valid; a rejected one leaves all state alone
// and returns status 1. The alarm compares hour, minute and second after a
// tick only, fires once and then disarms until it is set again. After reset
// the clock reads 00:00:00 on 1 January 1971 with the alarm disarmed. The
// block takes one transaction per clock cycle while m_axis_tready does not
// stall the output. An accepted transaction waits in the input register;
// the state update and the result register then take it in together. The
// state update reads and writes the time, date and alarm registers per step.

module clock_calendar_with_alarm (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // set_hour[6:0], set_minute[13:7], set_second[20:14], set_day[27:21],
  // set_month[34:28], set_year[48:35], zero fill[55:49]
  input  wire logic [55:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // now_second[5:0], now_minute[11:6], now_hour[16:12], now_day[21:17],
  // now_month[25:22], now_year[39:26]
  output logic [39:0]      m_axis_tdata,
  // alarm_fired[0], status[1]
  output logic [1:0]       m_axis_tuser
);

  logic            in_valid_q;
  ccal_pkg::item_t item_q;
  logic            out_valid_q;
  ccal_pkg::res_t  out_q;
  ccal_pkg::res_t  res;
  logic            out_free;
  logic            step;
  logic            in_take;

  // A result leaves the output register in the same cycle that a new one
  // enters it, so the pipeline never bubbles under a steady stream.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register. Payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op     <= ccal_pkg::op_e'(s_axis_tuser);
      item_q.hour   <= s_axis_tdata[6:0];
      item_q.minute <= s_axis_tdata[13:7];
      item_q.second <= s_axis_tdata[20:14];
      item_q.day    <= s_axis_tdata[27:21];
      item_q.month  <= s_axis_tdata[34:28];
      item_q.year   <= s_axis_tdata[48:35];
    end
  end

  // The state update happens exactly when the item moves into the result
  // register.
  ccal_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.year, out_q.month, out_q.day, out_q.hour,
                          out_q.minute, out_q.second};
  assign m_axis_tuser  = {out_q.reject, out_q.fired};

endmodule

`default_nettype wire
